[rtl/core/xs128_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// xs128_pkg
// Shared types, constants and the draw recurrence of the xorshift128 source.
// ---------------------------------------------------------------------------
package xs128_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned IDX_W     = $clog2(NUM_WORDS);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef enum logic
    {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } op_t;

    localparam word_t SEED_MULT  = 32'd1812433253;
    localparam int unsigned FOLD_SHIFT = 30;
    localparam int unsigned SH_A = 11;
    localparam int unsigned SH_B = 8;
    localparam int unsigned SH_C = 19;

    localparam word_t RESET_WORDS [NUM_WORDS] = '{
        32'd123456789,
        32'd362436069,
        32'd521288629,
        32'd88675123
    };

    function automatic word_t xs_next_word(input word_t first, input word_t last);
        word_t t;
        t = first ^ (first << SH_A);
        return (last ^ (last >> SH_C)) ^ (t ^ (t >> SH_B));
    endfunction

endpackage
`default_nettype wire

[rtl/core/xs128_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// xs128 channel interfaces
// Command channel (draw or reseed) and result channel (random word).
// ---------------------------------------------------------------------------
interface xs128_cmd_if
    import xs128_pkg::*;
    ;
    logic  valid;
    logic  ready;
    op_t   opcode;
    word_t seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface xs128_word_if
    import xs128_pkg::*;
    ;
    logic  valid;
    logic  ready;
    word_t random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

[rtl/core/xs128_seed_mul.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// xs128_seed_mul
// Shared seed multiplier: registers SEED_MULT * (s ^ (s >> 30)) mod 2^32.
// ---------------------------------------------------------------------------
module xs128_seed_mul
    import xs128_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  load,
    input  wire word_t operand,
    output word_t      product
);

    word_t folded;
    word_t product_reg;

    assign folded  = operand ^ (operand >> FOLD_SHIFT);
    assign product = product_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= word_t'(SEED_MULT * folded);
        end
    end

endmodule
`default_nettype wire

[rtl/core/xorshift128_random_source_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// xorshift128_random_source_top
// xorshift128 generator with a draw/reseed command channel and a word
// result channel.
//
// cmd carries opcode and seed_value; result carries random_word.
// A draw transfer computes the next word combinationally and presents it on
// result at the following edge; a new draw is taken every cycle as long as
// no reseed is running and the result register is empty or being taken in
// the same cycle. A reseed transfer gives no result and keeps cmd.ready low
// while one shared 32-bit multiplier is stepped once per generator word,
// until all four words have been reseeded.
// While result.valid is high and result.ready is low, the word holds and
// further draws are refused; reseeds are still taken.
// Reset returns the four words to their default values, empties the
// result register and returns to idle.
// ---------------------------------------------------------------------------
module xorshift128_random_source_top
    import xs128_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    xs128_cmd_if.sink   cmd,
    xs128_word_if.source result
);

    typedef enum logic
    {
        ST_IDLE,
        ST_SEED
    } state_t;

    state_t state_reg;
    state_t state_next;
    word_t  words_reg [NUM_WORDS];
    word_t  words_next [NUM_WORDS];
    idx_t   idx_reg;
    idx_t   idx_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    word_t  out_word_reg;
    word_t  out_word_next;

    logic   out_free;
    logic   cmd_xfer;
    logic   draw_xfer;
    logic   seed_xfer;
    logic   mul_load;
    word_t  mul_operand;
    word_t  mul_product;
    word_t  seed_word;
    word_t  draw_word;

    assign out_free  = !out_valid_reg || result.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && (out_free || cmd.opcode == OP_RESEED);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign draw_xfer = cmd_xfer && (cmd.opcode == OP_DRAW);
    assign seed_xfer = cmd_xfer && (cmd.opcode == OP_RESEED);

    assign seed_word   = mul_product + word_t'(idx_reg);
    assign draw_word   = xs_next_word(words_reg[0], words_reg[NUM_WORDS-1]);
    assign mul_load    = seed_xfer || (state_reg == ST_SEED);
    assign mul_operand = (state_reg == ST_IDLE) ? cmd.seed_value : seed_word;

    xs128_seed_mul u_seed_mul
    (
        .clk     (clk),
        .load    (mul_load),
        .operand (mul_operand),
        .product (mul_product)
    );

    assign result.valid       = out_valid_reg;
    assign result.random_word = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        words_next     = words_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_word_next  = out_word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (draw_xfer)
                begin
                    for (int i = 0; i < NUM_WORDS - 1; i++)
                    begin
                        words_next[i] = words_reg[i+1];
                    end
                    words_next[NUM_WORDS-1] = draw_word;
                    out_valid_next          = 1'b1;
                    out_word_next           = draw_word;
                end
                else if (seed_xfer)
                begin
                    idx_next   = '0;
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                for (int i = 0; i < NUM_WORDS - 1; i++)
                begin
                    words_next[i] = words_reg[i+1];
                end
                words_next[NUM_WORDS-1] = seed_word;
                idx_next                = idx_reg + 1'b1;
                if (idx_reg == idx_t'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            words_reg     <= RESET_WORDS;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            words_reg     <= words_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

`ifndef SYNTH
    a_seed_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        seed_xfer |=> !cmd.ready)
        else $error("command accepted during reseed");

    a_result_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(draw_xfer))
        else $error("result raised without a draw transfer");

    a_seed_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED) && (idx_reg == idx_t'(NUM_WORDS - 1)) |=>
            (state_reg == ST_IDLE))
        else $error("reseed did not finish after the last word");

    a_no_draw_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !draw_xfer)
        else $error("draw taken while result stalled");
`endif

endmodule
`default_nettype wire
